// ===== sv/mtasg_pkg.sv =====
// Shared types, constants and helper functions of the Mersenne Twister generator.
package mtasg_pkg;

	localparam int unsigned TW_N = 624;
	localparam int unsigned TW_M = 397;
	localparam int unsigned FAR_WRAP = TW_N - TW_M;
	localparam int unsigned IDX_W = 10;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TW_N - 1);
	localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(TW_N);

	localparam logic [31:0] SEED_INIT   = 32'd19650218;
	localparam logic [31:0] INIT_MULT   = 32'd1812433253;
	localparam logic [31:0] MIX_MULT_B  = 32'd1664525;
	localparam logic [31:0] MIX_MULT_C  = 32'd1566083941;
	localparam logic [31:0] TW_MATRIX   = 32'h9908b0df;
	localparam logic [31:0] TEMPER_B    = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C    = 32'hefc60000;
	localparam logic [31:0] TW_UPPER    = 32'h80000000;

	localparam logic [1:0] OP_RESEED = 2'd0;
	localparam logic [1:0] OP_DRAW   = 2'd1;
	localparam logic [1:0] OP_BELOW  = 2'd2;

	typedef struct packed {
		logic [IDX_W-1:0] addr_a;
		logic [IDX_W-1:0] addr_b;
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [31:0]      wdata;
	} mem_req_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [4:0] lead_zeros(input logic [31:0] v);
		logic [4:0] z;
		z = '0;
		for (int b = 0; b < 32; b++) begin
			if (v[b]) begin
				z = 5'(31 - b);
			end
		end
		return z;
	endfunction

endpackage

// ===== sv/mtasg_table.sv =====
// State table of the generator: one write port and two registered read ports.
module mtasg_table (
	input  logic                  clk,
	input  mtasg_pkg::mem_req_t   mem_req,
	output logic [31:0]           rd_a,
	output logic [31:0]           rd_b
);

	logic [31:0] mem [mtasg_pkg::TW_N];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
		rd_a <= mem[mem_req.addr_a];
		rd_b <= mem[mem_req.addr_b];
	end

endmodule

// ===== sv/mtasg_core.sv =====
// Sequencer of the generator: seeding, table regeneration, tempering and bounded draws.
module mtasg_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [1:0]                opcode,
	input  logic [63:0]               seed,
	input  logic [31:0]               bound,
	input  logic                      out_free,
	output logic                      rsp_push,
	output logic [31:0]               rsp_data,
	output mtasg_pkg::mem_req_t       mem_req,
	input  logic [31:0]               rd_a,
	input  logic [31:0]               rd_b
);

	localparam int unsigned IW = mtasg_pkg::IDX_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SA_MUL,
		ST_SA_ADD,
		ST_MX_MUL,
		ST_MX_WR,
		ST_SEED_TOP,
		ST_RG_PRIME,
		ST_RG_RUN,
		ST_DRAW_CHK,
		ST_DONE
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   idx_q;
	logic [63:0]     key_q;
	logic            key2_q;
	logic            below_q;
	logic [31:0]     bound_q;
	logic [4:0]      shift_q;
	logic [IW-1:0]   i_q;
	logic            j_q;
	logic            phase_c_q;
	logic [IW-1:0]   cnt_q;
	logic [31:0]     p_q;
	logic [31:0]     prod_q;
	logic [31:0]     cur_q;
	logic [31:0]     res_q;
	logic [IW-1:0]   n_q;
	logic [IW-1:0]   n_s1;
	logic            vld_s1;

	logic            accept;
	logic            draw_op;
	logic            idx_full;
	logic [31:0]     y_tmp;
	logic [31:0]     r_below;
	logic            chk_hit;
	logic [31:0]     chk_val;
	logic [31:0]     mix_in;
	logic [31:0]     mx_x;
	logic [31:0]     key_word;
	logic [31:0]     mx_v;
	logic [31:0]     sa_v;
	logic [31:0]     rg_y;
	logic [31:0]     rg_v;
	logic            issue;
	logic [IW-1:0]   nxt_n;
	logic [IW-1:0]   far_n;
	logic            rg_last;

	assign accept   = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign draw_op  = (opcode == mtasg_pkg::OP_DRAW) ||
	                  ((opcode == mtasg_pkg::OP_BELOW) && (bound != 32'd0));
	assign idx_full = (idx_q >= mtasg_pkg::IDX_FULL);

	assign y_tmp   = mtasg_pkg::temper(rd_a);
	assign r_below = y_tmp >> shift_q;
	assign chk_hit = (state_q == ST_DRAW_CHK) && (!below_q || (r_below < bound_q));
	assign chk_val = below_q ? r_below : y_tmp;

	assign rsp_push = out_free && ((state_q == ST_DONE) || chk_hit);
	assign rsp_data = (state_q == ST_DONE) ? res_q : chk_val;

	assign mix_in   = p_q ^ (p_q >> 30);
	assign sa_v     = prod_q + {{(32-IW){1'b0}}, i_q};
	assign mx_x     = rd_a ^ prod_q;
	assign key_word = j_q ? key_q[63:32] : key_q[31:0];
	assign mx_v     = phase_c_q ? (mx_x - {{(32-IW){1'b0}}, i_q})
	                            : (mx_x + key_word + {31'd0, j_q});

	assign rg_y = {cur_q[31], rd_a[30:0]};
	assign rg_v = rd_b ^ (rg_y >> 1) ^ (rg_y[0] ? mtasg_pkg::TW_MATRIX : 32'd0);

	assign issue   = (n_q < mtasg_pkg::IDX_FULL);
	assign nxt_n   = (n_q == mtasg_pkg::IDX_LAST) ? '0 : n_q + 1'b1;
	assign far_n   = (n_q < IW'(mtasg_pkg::FAR_WRAP)) ? n_q + IW'(mtasg_pkg::TW_M)
	                                                  : n_q - IW'(mtasg_pkg::FAR_WRAP);
	assign rg_last = vld_s1 && (n_s1 == mtasg_pkg::IDX_LAST);

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (opcode == mtasg_pkg::OP_RESEED)) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = '0;
					mem_req.wdata = mtasg_pkg::SEED_INIT;
				end
				mem_req.addr_a = idx_q;
			end
			ST_SA_ADD: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = i_q;
				mem_req.wdata = sa_v;
			end
			ST_MX_MUL: begin
				mem_req.addr_a = i_q;
			end
			ST_MX_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = i_q;
				mem_req.wdata = mx_v;
			end
			ST_SEED_TOP: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = '0;
				mem_req.wdata = mtasg_pkg::TW_UPPER;
			end
			ST_RG_PRIME: begin
				mem_req.addr_a = '0;
			end
			ST_RG_RUN: begin
				if (issue) begin
					mem_req.addr_a = nxt_n;
					mem_req.addr_b = far_n;
				end
				if (vld_s1) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = n_s1;
					mem_req.wdata = rg_v;
				end
			end
			ST_DRAW_CHK: begin
				mem_req.addr_a = idx_q;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= mtasg_pkg::IDX_FULL;
			key_q     <= '0;
			key2_q    <= 1'b0;
			below_q   <= 1'b0;
			bound_q   <= '0;
			shift_q   <= '0;
			i_q       <= '0;
			j_q       <= 1'b0;
			phase_c_q <= 1'b0;
			cnt_q     <= '0;
			p_q       <= '0;
			prod_q    <= '0;
			cur_q     <= '0;
			res_q     <= '0;
			n_q       <= '0;
			n_s1      <= '0;
			vld_s1    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == mtasg_pkg::OP_RESEED) begin
							key_q   <= seed;
							key2_q  <= (seed[63:32] != 32'd0);
							p_q     <= mtasg_pkg::SEED_INIT;
							i_q     <= IW'(1);
							state_q <= ST_SA_MUL;
						end else if (draw_op) begin
							below_q <= (opcode == mtasg_pkg::OP_BELOW);
							bound_q <= bound;
							shift_q <= mtasg_pkg::lead_zeros(bound);
							if (idx_full) begin
								state_q <= ST_RG_PRIME;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= ST_DRAW_CHK;
							end
						end else begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_SA_MUL: begin
					prod_q  <= mtasg_pkg::INIT_MULT * mix_in;
					state_q <= ST_SA_ADD;
				end
				ST_SA_ADD: begin
					if (i_q == mtasg_pkg::IDX_LAST) begin
						p_q       <= mtasg_pkg::SEED_INIT;
						i_q       <= IW'(1);
						j_q       <= 1'b0;
						cnt_q     <= mtasg_pkg::IDX_FULL;
						phase_c_q <= 1'b0;
						state_q   <= ST_MX_MUL;
					end else begin
						p_q     <= sa_v;
						i_q     <= i_q + 1'b1;
						state_q <= ST_SA_MUL;
					end
				end
				ST_MX_MUL: begin
					prod_q  <= (phase_c_q ? mtasg_pkg::MIX_MULT_C : mtasg_pkg::MIX_MULT_B) * mix_in;
					state_q <= ST_MX_WR;
				end
				ST_MX_WR: begin
					p_q <= mx_v;
					i_q <= (i_q == mtasg_pkg::IDX_LAST) ? IW'(1) : i_q + 1'b1;
					j_q <= key2_q ? ~j_q : 1'b0;
					if (cnt_q == IW'(1)) begin
						if (!phase_c_q) begin
							phase_c_q <= 1'b1;
							cnt_q     <= mtasg_pkg::IDX_LAST;
							state_q   <= ST_MX_MUL;
						end else begin
							state_q <= ST_SEED_TOP;
						end
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_MX_MUL;
					end
				end
				ST_SEED_TOP: begin
					idx_q   <= mtasg_pkg::IDX_FULL;
					res_q   <= '0;
					state_q <= ST_DONE;
				end
				ST_RG_PRIME: begin
					n_q     <= '0;
					vld_s1  <= 1'b0;
					state_q <= ST_RG_RUN;
				end
				ST_RG_RUN: begin
					cur_q <= rd_a;
					if (issue) begin
						n_s1   <= n_q;
						n_q    <= n_q + 1'b1;
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (rg_last) begin
						idx_q   <= IW'(1);
						state_q <= ST_DRAW_CHK;
					end
				end
				ST_DRAW_CHK: begin
					if (chk_hit) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							res_q   <= chk_val;
							state_q <= ST_DONE;
						end
					end else if (idx_full) begin
						state_q <= ST_RG_PRIME;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/mt19937_array_seeded_generator_unit.sv =====
// Top level of the Mersenne Twister generator with array seeding and bounded draws.
//
//   channel   signals                           transaction
//   request   req_valid, req_stall, opcode,     one operation: reseed, draw or bounded draw
//             seed, bound
//   response  rsp_valid, rsp_stall, value       one result word per request
//
// A draw reads the table, then tempers and delivers the word.
// Every 624th word first regenerates the table, one entry a cycle on two
// read ports. A bounded draw repeats the draw once for every rejected word.
// A reseed walks the table three times through the 32-bit multiplier.
// After reset the table is unwritten and the first
// operation must be a reseed. The result waits in an output register, so a stalled
// response holds the next request only once that request has its own result ready.
module mt19937_array_seeded_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [63:0] seed,
	input  logic [31:0] bound,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] value
);

	mtasg_pkg::mem_req_t mem_req;
	logic [31:0]         rd_a;
	logic [31:0]         rd_b;
	logic                out_free;
	logic                rsp_push;
	logic [31:0]         rsp_data;
	logic                rsp_valid_q;
	logic [31:0]         value_q;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;

	mtasg_table u_table (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_a    (rd_a),
		.rd_b    (rd_b)
	);

	mtasg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.opcode    (opcode),
		.seed      (seed),
		.bound     (bound),
		.out_free  (out_free),
		.rsp_push  (rsp_push),
		.rsp_data  (rsp_data),
		.mem_req   (mem_req),
		.rd_a      (rd_a),
		.rd_b      (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			value_q     <= '0;
		end else begin
			if (rsp_push) begin
				rsp_valid_q <= 1'b1;
				value_q     <= rsp_data;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/mtasg_checker.sv =====
// Port-level checker of the generator and the bind that attaches it to the top level.
module mtasg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic [1:0]  opcode,
	input logic [63:0] seed,
	input logic [31:0] bound,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] value
);

	logic [1:0] pend_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, req_acc} - {1'b0, rsp_acc};
		end
	end

	// A response is only ever shown for a transaction that has been taken in.
	a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pend_q != 2'd0))
		else $error("response shown with no request outstanding");

	// At most one finished result waits while one more request is in work.
	a_pend_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd2) |-> req_stall)
		else $error("request accepted with two transactions outstanding");

	// A stalled response keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(value)))
		else $error("stalled response changed or vanished");

	// A stalled request keeps its payload.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_stall) |=>
			(req_valid && $stable(opcode) && $stable(seed) && $stable(bound)))
		else $error("stalled request changed or vanished");

	// No response appears when no transaction is outstanding and none arrives.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		((pend_q == 2'd0) && !req_acc) |=> !rsp_valid)
		else $error("response appeared without a request");

endmodule

bind mt19937_array_seeded_generator_unit mtasg_checker u_mtasg_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench of the Mersenne Twister generator with array seeding and bounded draws.
module testbench;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  opcode;
		logic [63:0] seed;
		logic [31:0] bound;
		int          phase;
	} mt_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  opcode = mtasg_pkg::OP_RESEED;
	logic [63:0] seed = '0;
	logic [31:0] bound = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [31:0] value;

	mt_item_t    pending [$];
	mt_item_t    cur_item;
	logic [31:0] exp_values [$];
	int unsigned errors = 0;
	int          run_phase = 0;
	bit          send_calm = 1'b0;
	bit          recv_calm = 1'b0;
	int          send_idle_pct [4] = '{0, 45, 0, 37};
	int          recv_stall_pct [4] = '{0, 0, 45, 37};

	logic [31:0] tw_state [mtasg_pkg::TW_N];
	int unsigned tw_pos = mtasg_pkg::TW_N;

	mt19937_array_seeded_generator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.opcode    (opcode),
		.seed      (seed),
		.bound     (bound),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value     (value)
	);

	always #5 clk = ~clk;

	function automatic void mt_reseed(input logic [63:0] s);
		logic [31:0] key [2];
		int unsigned klen, i, j, k;
		logic [31:0] p;
		key[0] = s[31:0];
		key[1] = s[63:32];
		klen = (key[1] != 32'd0) ? 2 : 1;
		tw_state[0] = mtasg_pkg::SEED_INIT;
		for (i = 1; i < mtasg_pkg::TW_N; i++) begin
			p = tw_state[i-1];
			tw_state[i] = mtasg_pkg::INIT_MULT * (p ^ (p >> 30)) + 32'(i);
		end
		i = 1;
		j = 0;
		for (k = mtasg_pkg::TW_N; k != 0; k--) begin
			p = tw_state[i-1];
			tw_state[i] = (tw_state[i] ^ ((p ^ (p >> 30)) * mtasg_pkg::MIX_MULT_B))
				+ key[j & 1] + 32'(j);
			i++;
			j++;
			if (j >= klen) j = 0;
			if (i >= mtasg_pkg::TW_N) begin
				tw_state[0] = tw_state[mtasg_pkg::TW_N-1];
				i = 1;
			end
		end
		for (k = mtasg_pkg::TW_N - 1; k != 0; k--) begin
			p = tw_state[i-1];
			tw_state[i] = (tw_state[i] ^ ((p ^ (p >> 30)) * mtasg_pkg::MIX_MULT_C))
				- 32'(i);
			i++;
			if (i >= mtasg_pkg::TW_N) begin
				tw_state[0] = tw_state[mtasg_pkg::TW_N-1];
				i = 1;
			end
		end
		tw_state[0] = mtasg_pkg::TW_UPPER;
		tw_pos = mtasg_pkg::TW_N;
	endfunction

	function automatic void mt_refill();
		logic [31:0] y;
		for (int n = 0; n < mtasg_pkg::TW_N; n++) begin
			y = (tw_state[n] & mtasg_pkg::TW_UPPER) |
				(tw_state[(n + 1) % mtasg_pkg::TW_N] & ~mtasg_pkg::TW_UPPER);
			tw_state[n] = tw_state[(n + mtasg_pkg::TW_M) % mtasg_pkg::TW_N] ^ (y >> 1) ^
				(y[0] ? mtasg_pkg::TW_MATRIX : 32'd0);
		end
		tw_pos = 0;
	endfunction

	function automatic logic [31:0] mt_next();
		logic [31:0] y;
		if (tw_pos >= mtasg_pkg::TW_N) mt_refill();
		y = tw_state[tw_pos];
		tw_pos++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & mtasg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtasg_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [31:0] mt_below(input logic [31:0] b);
		int unsigned nbits;
		logic [31:0] v, r;
		if (b == 32'd0) return 32'd0;
		nbits = 0;
		v = b;
		while (v != 32'd0) begin
			nbits++;
			v = v >> 1;
		end
		do begin
			r = mt_next() >> (32 - nbits);
		end while (r >= b);
		return r;
	endfunction

	function automatic logic [31:0] mt_predict(input mt_item_t it);
		case (it.opcode)
			mtasg_pkg::OP_RESEED: begin
				mt_reseed(it.seed);
				return 32'd0;
			end
			mtasg_pkg::OP_DRAW:  return mt_next();
			mtasg_pkg::OP_BELOW: return mt_below(it.bound);
			default:  return 32'd0;
		endcase
	endfunction

	function automatic void queue_item(input logic [1:0] op, input logic [63:0] s,
		input logic [31:0] b, input int ph);
		mt_item_t it;
		it.opcode = op;
		it.seed = s;
		it.bound = b;
		it.phase = ph;
		pending.insert(pending.size(), it);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic go;
		int ph;
		if (!arst_n) begin
			req_valid <= 1'b0;
			opcode <= mtasg_pkg::OP_RESEED;
			seed <= '0;
			bound <= '0;
		end else begin
			go = 1'b0;
			ph = run_phase;
			if (req_valid && !req_stall) begin
				exp_values.insert(exp_values.size(), mt_predict(cur_item));
			end
			if (!req_valid || !req_stall) begin
				if ($urandom_range(63) == 0) send_calm = !send_calm;
				if (pending.size() != 0) begin
					if (pending[0].phase != ph && exp_values.size() == 0) ph = pending[0].phase;
					if (pending[0].phase == ph &&
						(send_calm || $urandom_range(99) >= send_idle_pct[ph])) go = 1'b1;
				end
				if (go) begin
					cur_item = pending.pop_front();
					opcode <= cur_item.opcode;
					seed <= cur_item.seed;
					bound <= cur_item.bound;
				end
				req_valid <= go;
			end
			run_phase <= ph;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (exp_values.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual value %h",
						$time, value);
					errors++;
				end else begin
					want = exp_values.pop_front();
					if (value !== want) begin
						$display("%0t: value mismatch, expected %h, actual %h", $time, want, value);
						errors++;
					end
				end
			end
			if ($urandom_range(63) == 0) recv_calm = !recv_calm;
			rsp_stall <= !recv_calm && ($urandom_range(99) < recv_stall_pct[run_phase]);
		end
	end

	initial begin
		int p, r, bits;
		int unsigned seg, cnt, budget;
		logic [31:0] b;
		logic [1:0] op;

		queue_item(mtasg_pkg::OP_RESEED, 64'd0, $urandom, 0);
		queue_item(mtasg_pkg::OP_DRAW, {$urandom, $urandom}, $urandom, 0);
		queue_item(mtasg_pkg::OP_BELOW, {$urandom, $urandom}, 32'd1, 0);
		queue_item(mtasg_pkg::OP_BELOW, {$urandom, $urandom}, 32'hffffffff, 0);
		queue_item(mtasg_pkg::OP_BELOW, {$urandom, $urandom}, 32'h80000000, 0);
		queue_item(mtasg_pkg::OP_BELOW, {$urandom, $urandom}, 32'h80000001, 0);
		queue_item(mtasg_pkg::OP_BELOW, {$urandom, $urandom}, 32'd2, 0);
		queue_item(mtasg_pkg::OP_BELOW, {$urandom, $urandom}, 32'd0, 0);
		queue_item(OP_UNUSED, {$urandom, $urandom}, $urandom, 0);
		queue_item(mtasg_pkg::OP_DRAW, {$urandom, $urandom}, $urandom, 0);
		queue_item(mtasg_pkg::OP_RESEED, 64'hffffffff_ffffffff, $urandom, 0);
		queue_item(mtasg_pkg::OP_DRAW, {$urandom, $urandom}, $urandom, 0);
		queue_item(mtasg_pkg::OP_DRAW, {$urandom, $urandom}, $urandom, 0);
		queue_item(mtasg_pkg::OP_RESEED, 64'h00000000_ffffffff, $urandom, 0);
		queue_item(mtasg_pkg::OP_DRAW, {$urandom, $urandom}, $urandom, 0);
		queue_item(mtasg_pkg::OP_BELOW, {$urandom, $urandom}, 32'h7fffffff, 0);
		queue_item(mtasg_pkg::OP_RESEED, 64'h00000001_00000000, $urandom, 0);
		queue_item(mtasg_pkg::OP_DRAW, {$urandom, $urandom}, $urandom, 0);
		queue_item(mtasg_pkg::OP_BELOW, {$urandom, $urandom}, 32'd3, 0);
		queue_item(mtasg_pkg::OP_RESEED, 64'h80000000_00000001, $urandom, 0);
		queue_item(mtasg_pkg::OP_DRAW, {$urandom, $urandom}, $urandom, 0);

		// The first sequence of the run is long enough to wrap the table past a full refill.
		for (p = 0; p < 4; p++) begin
			budget = (p == 0) ? 660 : 280;
			cnt = 0;
			while (cnt < budget) begin
				queue_item(mtasg_pkg::OP_RESEED,
					{($urandom_range(1) ? $urandom : 32'd0), $urandom}, $urandom, p);
				seg = (p == 0 && cnt == 0) ? 640 : $urandom_range(1, 50);
				cnt += seg + 1;
				repeat (seg) begin
					r = $urandom_range(99);
					bits = $urandom_range(1, 32);
					b = $urandom & (32'hffffffff >> (32 - bits));
					if ($urandom_range(3) != 0) b[bits-1] = 1'b1;
					if (b == 32'd0) b = 32'd1;
					if (r < 50) begin
						op = mtasg_pkg::OP_DRAW;
					end else if (r < 94) begin
						op = mtasg_pkg::OP_BELOW;
					end else if (r < 97) begin
						op = mtasg_pkg::OP_BELOW;
						b = 32'd0;
					end else begin
						op = OP_UNUSED;
					end
					queue_item(op, {$urandom, $urandom}, b, p);
				end
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0 || req_valid || exp_values.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#15000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
